/* hw/rtl/lhs_pkg.sv */
// Shared widths, operation codes and status codes for the linear probe hash set.
// No dependencies; imported by the top level.
package lhs_pkg;

    // field widths fixed by the request and result formats
    localparam int FUNC_W     = 2;
    localparam int KEY_IN_W   = 32;
    localparam int HASH_W     = 32;
    localparam int STATUS_W   = 3;
    localparam int COUNT_W    = 11;
    localparam int SIZE_W     = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    // stream payload widths, padded to whole bytes
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 16;

    // operations
    localparam logic [FUNC_W-1:0] FUNC_FIND   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd3;

    // result status
    localparam logic [STATUS_W-1:0] ST_DONE    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PRESENT = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ABSENT  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BADKEY  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FOUND   = 3'd5;

    // configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_LOG2   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ENTRIES = 1'd1;
    localparam logic [SIZE_W-1:0]    SIZE_LOG2_RST   = 4'd10;
    localparam logic [COUNT_W-1:0]   MAX_ENTRIES_RST = 11'd768;

endpackage

/* hw/rtl/lhs_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module lhs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write, and register the read word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/linear_probe_hash_set.sv */
// Linear probe hash set: request stream in, one result per request out.
// A slave stream carries requests: tuser holds the operation, tdata the key and its hash.
// A master stream returns one result per request: tuser holds the status, tdata the
// live key count after the request. Keys 0 and all-ones are rejected as bad keys.
// Requests are taken one at a time: a request goes from idle through its walk and a result
// state into the output register, and the next request can transfer once the block is
// back in idle. The walk reads one slot per cycle from the slot memory's single read port,
// and stops at the key, at an empty slot, or after every slot in use.
// A clear request sweeps the whole slot memory, one slot per cycle, before its result.
// When the table is the full memory and TABLE_SLOTS is not a power of two, the home slot
// is found first by a remainder unit. After reset the same sweep runs with s_tready low;
// configuration writes are taken throughout.
// A result waits in an output register while the receiver stalls; one more request
// is still taken and worked, and its result is held back until the register frees.
// Uses lhs_pkg and lhs_ram.
module linear_probe_hash_set #(
    parameter int TABLE_SLOTS = 1024,
    parameter int KEY_BITS    = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [lhs_pkg::S_TDATA_W-1:0]     i_s_tdata,  // [31:0] key, [63:32] key_hash
    input  logic [lhs_pkg::FUNC_W-1:0]        i_s_tuser,  // [1:0] func
    // result stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [lhs_pkg::M_TDATA_W-1:0]     o_m_tdata,  // [10:0] live_count, rest zero
    output logic [lhs_pkg::STATUS_W-1:0]      o_m_tuser,  // [2:0] status
    // configuration writes
    input  logic                              i_cfg_we,
    input  logic [lhs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [lhs_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    import lhs_pkg::*;

    localparam int  IDX_W      = $clog2(TABLE_SLOTS);
    localparam int  CNT_W      = $clog2(TABLE_SLOTS + 1);
    localparam int  CAP_LOG    = $clog2(TABLE_SLOTS);
    localparam bit  SLOTS_POW2 = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;
    localparam int  DIGIT_W    = 4;
    localparam int  MOD_STEPS  = HASH_W / DIGIT_W;
    localparam int  BIT_W      = $clog2(MOD_STEPS);
    localparam logic [KEY_BITS-1:0] DEL_MARK   = '1;
    localparam logic [KEY_BITS-1:0] EMPTY_MARK = '0;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_ISSUE,
        S_PROBE,
        S_RESP
    } t_state;

    t_state                r_state;
    logic [SIZE_W-1:0]     r_size_log2;
    logic [COUNT_W-1:0]    r_max_entries;
    logic [COUNT_W-1:0]    r_count;
    logic [FUNC_W-1:0]     r_func;
    logic [KEY_BITS-1:0]   r_key;
    logic [CNT_W-1:0]      r_n;
    logic [IDX_W-1:0]      r_cur;
    logic [CNT_W-1:0]      r_step;
    logic                  r_free_vld;
    logic [IDX_W-1:0]      r_free;
    logic                  r_clr_reply;
    logic [STATUS_W-1:0]   r_status;
    logic [HASH_W-1:0]     r_hash;
    logic [CNT_W-1:0]      r_rem;
    logic [BIT_W-1:0]      r_bit;
    logic                  r_out_valid;
    logic [STATUS_W-1:0]   r_out_status;
    logic [COUNT_W-1:0]    r_out_count;

    logic [FUNC_W-1:0]     w_in_func;
    logic [KEY_BITS-1:0]   w_in_key;
    logic [HASH_W-1:0]     w_in_hash;
    logic                  w_accept;
    logic                  w_bad_key;
    logic [SIZE_W-1:0]     w_s;
    logic                  w_capped;
    logic [CNT_W-1:0]      w_n_cfg;
    logic [IDX_W-1:0]      w_mask;
    logic [IDX_W-1:0]      w_home;
    logic                  w_need_mod;
    logic [CNT_W+DIGIT_W-1:0] w_rem_sh;
    logic [CNT_W-1:0]      w_rem_nx;
    logic [IDX_W-1:0]      w_next;
    logic [KEY_BITS-1:0]   w_slot;
    logic                  w_is_empty;
    logic                  w_is_del;
    logic                  w_is_hit;
    logic                  w_last;
    logic                  w_end;
    logic                  w_have_free;
    logic [IDX_W-1:0]      w_free_idx;
    logic                  w_limit;
    logic                  w_we;
    logic [IDX_W-1:0]      w_waddr;
    logic [KEY_BITS-1:0]   w_wdata;
    logic [IDX_W-1:0]      w_raddr;
    logic                  w_out_load;

    // unpack the request
    assign w_in_func = i_s_tuser;
    assign w_in_key  = KEY_BITS'(i_s_tdata[KEY_IN_W-1:0]);
    assign w_in_hash = i_s_tdata[KEY_IN_W +: HASH_W];
    assign w_accept  = i_s_tvalid && o_s_tready;
    assign w_bad_key = (w_in_key == EMPTY_MARK) || (w_in_key == DEL_MARK);

    // slots in use and home slot from the configured size
    assign w_s        = (r_size_log2 == '0) ? SIZE_W'(1) : r_size_log2;
    assign w_capped   = int'(w_s) >= CAP_LOG;
    assign w_n_cfg    = w_capped ? CNT_W'(TABLE_SLOTS) : (CNT_W'(1) << w_s);
    assign w_need_mod = !SLOTS_POW2 && w_capped;

    always_comb begin
        for (int i = 0; i < IDX_W; i++) begin
            w_mask[i] = w_capped || (i < int'(w_s));
        end
    end

    assign w_home = w_in_hash[IDX_W-1:0] & w_mask;

    // remainder by the table size, one four-bit hash digit per cycle:
    // shift the digit in, then take off eight, four, two and one times the size
    always_comb begin
        w_rem_sh = {r_rem, r_hash[HASH_W-1 -: DIGIT_W]};
        for (int j = DIGIT_W - 1; j >= 0; j--) begin
            if (w_rem_sh >= ((CNT_W + DIGIT_W)'(TABLE_SLOTS) << j)) begin
                w_rem_sh = w_rem_sh - ((CNT_W + DIGIT_W)'(TABLE_SLOTS) << j);
            end
        end
        w_rem_nx = w_rem_sh[CNT_W-1:0];
    end

    // wrap the walk at the slots in use
    assign w_next = ((CNT_W'(r_cur) + CNT_W'(1)) == r_n) ? '0 : r_cur + IDX_W'(1);

    // examine the slot read last cycle
    assign w_is_empty  = (w_slot == EMPTY_MARK);
    assign w_is_del    = (w_slot == DEL_MARK);
    assign w_is_hit    = (w_slot == r_key);
    assign w_last      = (r_step == r_n - CNT_W'(1));
    assign w_end       = w_is_empty || w_is_hit || w_last;
    assign w_have_free = r_free_vld || w_is_empty || w_is_del;
    assign w_free_idx  = r_free_vld ? r_free : r_cur;
    assign w_limit     = (r_count >= r_max_entries);

    // slot memory write: clearing sweep, insert of a key, or removal mark
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_cur;
        w_wdata = EMPTY_MARK;
        if (r_state == S_CLEAR) begin
            w_we = 1'b1;
        end else if (r_state == S_PROBE && w_end) begin
            if (w_is_hit && r_func == FUNC_REMOVE) begin
                w_we    = 1'b1;
                w_wdata = DEL_MARK;
            end else if (!w_is_hit && r_func == FUNC_INSERT && !w_limit && w_have_free) begin
                w_we    = 1'b1;
                w_waddr = w_free_idx;
                w_wdata = r_key;
            end
        end
    end

    // slot memory read address
    always_comb begin
        unique case (r_state)
            S_IDLE:  w_raddr = w_home;
            S_PROBE: w_raddr = w_next;
            default: w_raddr = r_cur;
        endcase
    end

    lhs_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (TABLE_SLOTS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_slot)
    );

    assign w_out_load = (r_state == S_RESP) && (!r_out_valid || i_m_tready);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_log2   <= SIZE_LOG2_RST;
            r_max_entries <= MAX_ENTRIES_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SIZE_LOG2:   r_size_log2   <= i_cfg_data[SIZE_W-1:0];
                REG_MAX_ENTRIES: r_max_entries <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // request sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cur       <= '0;
            r_count     <= '0;
            r_clr_reply <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_m_tready && !w_out_load) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_cur <= r_cur + IDX_W'(1);
                    if (r_cur == IDX_W'(TABLE_SLOTS - 1)) begin
                        r_status <= ST_DONE;
                        r_state  <= r_clr_reply ? S_RESP : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_func     <= w_in_func;
                        r_key      <= w_in_key;
                        r_n        <= w_n_cfg;
                        r_cur      <= (w_in_func == FUNC_CLEAR) ? '0 : w_home;
                        r_step     <= '0;
                        r_free_vld <= 1'b0;
                        r_hash     <= w_in_hash;
                        r_rem      <= '0;
                        r_bit      <= '0;
                        if (w_in_func == FUNC_CLEAR) begin
                            r_count     <= '0;
                            r_clr_reply <= 1'b1;
                            r_state     <= S_CLEAR;
                        end else if (w_bad_key) begin
                            r_status <= ST_BADKEY;
                            r_state  <= S_RESP;
                        end else if (w_need_mod) begin
                            r_state <= S_MOD;
                        end else begin
                            r_state <= S_PROBE;
                        end
                    end
                end
                S_MOD: begin
                    r_rem  <= w_rem_nx;
                    r_hash <= r_hash << DIGIT_W;
                    r_bit  <= r_bit + BIT_W'(1);
                    if (r_bit == BIT_W'(MOD_STEPS - 1)) begin
                        r_cur   <= w_rem_nx[IDX_W-1:0];
                        r_state <= S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    r_state <= S_PROBE;
                end
                S_PROBE: begin
                    if (w_end) begin
                        r_state <= S_RESP;
                        if (w_is_hit) begin
                            unique case (r_func)
                                FUNC_FIND:   r_status <= ST_FOUND;
                                FUNC_INSERT: r_status <= ST_PRESENT;
                                default: begin
                                    r_status <= ST_DONE;
                                    if (r_count != '0) begin
                                        r_count <= r_count - COUNT_W'(1);
                                    end
                                end
                            endcase
                        end else if (r_func == FUNC_INSERT) begin
                            if (!w_limit && w_have_free) begin
                                r_status <= ST_DONE;
                                r_count  <= r_count + COUNT_W'(1);
                            end else begin
                                r_status <= ST_FULL;
                            end
                        end else begin
                            r_status <= ST_ABSENT;
                        end
                    end else begin
                        // remember the first deleted slot for a later insert
                        if (w_is_del && !r_free_vld) begin
                            r_free_vld <= 1'b1;
                            r_free     <= r_cur;
                        end
                        r_cur  <= w_next;
                        r_step <= r_step + CNT_W'(1);
                    end
                end
                S_RESP: begin
                    if (w_out_load) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_status;
                        r_out_count  <= r_count;
                        r_clr_reply  <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = M_TDATA_W'(r_out_count);

`ifndef NO_ASSERTIONS
    // the slot memory is written only by the sweep or at the end of a walk
    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_CLEAR || r_state == S_PROBE))
        else $error("slot write outside sweep or walk");

    // a walk never examines more slots than are in use
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE) |-> (r_step < r_n))
        else $error("walk ran past the slots in use");

    // a stored key raises the live count by one
    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE && w_we && r_func == FUNC_INSERT)
        |=> (r_count == COUNT_W'($past(r_count) + 1'b1)))
        else $error("insert did not advance the live count");

    // a finished result always reaches the output register
    a_result_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> (r_out_valid && r_state == S_IDLE))
        else $error("result not loaded into output register");
`endif

endmodule

/* test/tb_linear_probe_hash_set.sv */
`timescale 1ns / 1ps
// Self-checking testbench for linear_probe_hash_set: directed and random requests
// against an in-bench model of the probed key table. Depends on lhs_pkg and the RTL.
module tb_linear_probe_hash_set;
    import lhs_pkg::*;

    localparam int TABLE_SLOTS = 1024;
    localparam int POOL_KEYS   = 48;
    localparam int PHASE_ITEMS = 175;
    localparam int N_PHASES    = 10;

    // expected result of one request
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
    } t_set_result;

    // Model of the key table and the queue of results it predicts
    class hash_set_scoreboard;
        logic [KEY_IN_W-1:0] slot_mem [TABLE_SLOTS];
        int unsigned         live;
        int unsigned         size_cfg;
        int unsigned         max_cfg;
        int unsigned         errors;
        t_set_result         expected_q [$];

        function new();
            foreach (slot_mem[i]) slot_mem[i] = '0;
            live     = 0;
            size_cfg = 32'(SIZE_LOG2_RST);
            max_cfg  = 32'(MAX_ENTRIES_RST);
            errors   = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == REG_SIZE_LOG2)
                size_cfg = 32'(val[SIZE_W-1:0]);
            else
                max_cfg = 32'(val);
        endfunction

        // slots in use: size 0 counts as 1, oversize is cut to the memory
        function int unsigned slot_count();
            int unsigned s;
            s = (size_cfg == 0) ? 1 : size_cfg;
            if (s > 10)
                return TABLE_SLOTS;
            return 1 << s;
        endfunction

        // walk from home until the key, an empty slot, or one full lap
        function bit find_slot(logic [KEY_IN_W-1:0] k, int unsigned home, int unsigned n,
                               output int unsigned at);
            int unsigned idx;
            int unsigned step;
            idx = home;
            at  = 0;
            for (step = 0; step < n; step++) begin
                if (slot_mem[idx] == '0)
                    return 1'b0;
                if (slot_mem[idx] != '1 && slot_mem[idx] == k) begin
                    at = idx;
                    return 1'b1;
                end
                idx = (idx + 1 == n) ? 0 : idx + 1;
            end
            return 1'b0;
        endfunction

        // apply one accepted request to the table and queue its result
        function void note_request(logic [FUNC_W-1:0] op, logic [KEY_IN_W-1:0] k,
                                   logic [HASH_W-1:0] h);
            int unsigned n;
            int unsigned home;
            int unsigned at;
            int unsigned idx;
            int unsigned step;
            logic [STATUS_W-1:0] st;
            t_set_result r;
            n    = slot_count();
            home = h & (n - 1);
            st   = ST_DONE;
            if (op == FUNC_CLEAR) begin
                foreach (slot_mem[i]) slot_mem[i] = '0;
                live = 0;
            end else if (k == '0 || k == '1) begin
                st = ST_BADKEY;
            end else if (op == FUNC_FIND) begin
                st = find_slot(k, home, n, at) ? ST_FOUND : ST_ABSENT;
            end else if (op == FUNC_INSERT) begin
                if (find_slot(k, home, n, at)) begin
                    st = ST_PRESENT;
                end else begin
                    st = ST_FULL;
                    if (live < max_cfg) begin
                        idx = home;
                        for (step = 0; step < n; step++) begin
                            if (slot_mem[idx] == '0 || slot_mem[idx] == '1) begin
                                slot_mem[idx] = k;
                                live = live + 1;
                                st = ST_DONE;
                                break;
                            end
                            idx = (idx + 1 == n) ? 0 : idx + 1;
                        end
                    end
                end
            end else begin
                if (find_slot(k, home, n, at)) begin
                    slot_mem[at] = '1;
                    if (live > 0)
                        live = live - 1;
                    st = ST_DONE;
                end else begin
                    st = ST_ABSENT;
                end
            end
            r.status = st;
            r.count  = live[COUNT_W-1:0];
            expected_q.push_back(r);
        endfunction

        // compare one result transfer with the oldest expectation
        function void check_result(logic [STATUS_W-1:0] st, logic [M_TDATA_W-1:0] td);
            t_set_result r;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result, status %0d count %0d",
                         $time, st, td);
                errors++;
                return;
            end
            r = expected_q.pop_front();
            if (st !== r.status) begin
                $display("%0t: status expected %0d actual %0d", $time, r.status, st);
                errors++;
            end
            if (td !== {{(M_TDATA_W-COUNT_W){1'b0}}, r.count}) begin
                $display("%0t: live count expected %0d actual %0d", $time, r.count, td);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [S_TDATA_W-1:0]  i_s_tdata  = '0;  // [31:0] key, [63:32] key_hash
    logic [FUNC_W-1:0]     i_s_tuser  = FUNC_FIND;  // [1:0] func
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  o_m_tdata;  // [10:0] live_count, rest zero
    logic [STATUS_W-1:0]   o_m_tuser;  // [2:0] status
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = REG_SIZE_LOG2;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    hash_set_scoreboard    sb;
    bit                    idle_on = 1'b1;
    int unsigned           stall_left = 0;
    logic [KEY_IN_W-1:0]   pool_key  [POOL_KEYS];
    logic [HASH_W-1:0]     pool_hash [POOL_KEYS];

    linear_probe_hash_set dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Check result transfers and stall the receiver in random bursts
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_result(o_m_tuser, o_m_tdata);
        if (stall_left != 0) begin
            stall_left = stall_left - 1;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 11) - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Offer one request, after an optional gap, and hold it until its transfer
    task automatic send_req(input logic [FUNC_W-1:0] op, input logic [KEY_IN_W-1:0] k,
                            input logic [HASH_W-1:0] h);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {h, k};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_request(op, k, h);
    endtask

    // Drop valid and wait for every outstanding result
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Write both registers while the block is idle
    task automatic set_config(input logic [SIZE_W-1:0] sz, input logic [COUNT_W-1:0] lim);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_SIZE_LOG2;
        i_cfg_data <= {{(CFG_DATA_W-SIZE_W){1'b0}}, sz};
        @(posedge i_clk);
        i_cfg_idx  <= REG_MAX_ENTRIES;
        i_cfg_data <= lim;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.write_reg(REG_SIZE_LOG2, CFG_DATA_W'(sz));
        sb.write_reg(REG_MAX_ENTRIES, lim);
    endtask

    // Mostly pool keys with their own hash; some clears, reserved keys and noise
    task automatic random_item(input int unsigned pool_lim);
        int unsigned       r;
        int unsigned       pick;
        logic [FUNC_W-1:0] op;
        r    = $urandom_range(0, 99);
        pick = $urandom_range(0, pool_lim - 1);
        op   = FUNC_W'($urandom_range(FUNC_FIND, FUNC_REMOVE));
        if (r < 2)
            send_req(FUNC_CLEAR, $urandom, $urandom);
        else if (r < 5)
            send_req(op, $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF, $urandom);
        else if (r < 9)
            send_req(op, $urandom, $urandom);
        else if (r < 42)
            send_req(FUNC_INSERT, pool_key[pick], pool_hash[pick]);
        else if (r < 72)
            send_req(FUNC_FIND, pool_key[pick], pool_hash[pick]);
        else
            send_req(FUNC_REMOVE, pool_key[pick], pool_hash[pick]);
    endtask

    // Hard limit on the run
    initial begin
        #80_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int unsigned      phase_size [N_PHASES];
        int unsigned      phase_lim  [N_PHASES];
        int unsigned      pool_lim;
        logic [HASH_W-1:0] hv;
        phase_size = '{1, 0, 3, 4, 15, 2, 6, 12, 5, 10};
        phase_lim  = '{1024, 2, 6, 0, 1024, 1024, 40, 30, 1024, 768};
        sb = new();

        // pool keys avoid the reserved values; homes cluster around the wrap point
        foreach (pool_key[i]) begin
            pool_key[i] = $urandom;
            while (pool_key[i] == '0 || pool_key[i] == '1) pool_key[i] = $urandom;
            hv = $urandom;
            hv[9:0] = 10'((1020 + $urandom_range(0, 11)) % TABLE_SLOTS);
            pool_hash[i] = hv;
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // basic operations at the reset settings, wrap at the top slot, deleted marks
        send_req(FUNC_FIND,   32'h0000_0002, 32'h0);
        send_req(FUNC_INSERT, 32'h0000_0002, 32'h0);
        send_req(FUNC_INSERT, 32'h0000_0002, 32'h0);
        send_req(FUNC_FIND,   32'h0000_0002, 32'h0);
        send_req(FUNC_INSERT, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
        send_req(FUNC_INSERT, 32'h0000_0001, 32'hFFFF_FFFF);
        send_req(FUNC_FIND,   32'h0000_0001, 32'hFFFF_FFFF);
        send_req(FUNC_REMOVE, 32'h0000_0002, 32'h0);
        send_req(FUNC_REMOVE, 32'h0000_0002, 32'h0);
        send_req(FUNC_FIND,   32'h0000_0001, 32'hFFFF_FFFF);
        // reserved keys
        send_req(FUNC_FIND,   32'h0, 32'h5);
        send_req(FUNC_INSERT, 32'hFFFF_FFFF, 32'h0);
        send_req(FUNC_REMOVE, 32'h0, 32'hFFFF_FFFF);
        send_req(FUNC_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain_results();

        // two-slot table: full by table, bounded walk, reuse of a deleted slot
        set_config(4'd1, 11'd1024);
        send_req(FUNC_INSERT, 32'hA5A5_0001, 32'h0);
        send_req(FUNC_INSERT, 32'h5A5A_0002, 32'h2);
        send_req(FUNC_INSERT, 32'h1234_5678, 32'h1);
        send_req(FUNC_FIND,   32'h1234_5678, 32'h1);
        send_req(FUNC_REMOVE, 32'hA5A5_0001, 32'h0);
        send_req(FUNC_INSERT, 32'h1234_5678, 32'h1);
        drain_results();

        // full by limit, then size 0 treated as two slots
        set_config(4'd1, 11'd1);
        send_req(FUNC_INSERT, 32'h8000_0000, 32'h0);
        send_req(FUNC_REMOVE, 32'h1234_5678, 32'h1);
        drain_results();
        set_config(4'd0, 11'd1024);
        send_req(FUNC_FIND,   32'h5A5A_0002, 32'h3);
        drain_results();

        // random phases; contents carry over between sizes, last phase runs flat out
        for (int p = 0; p < N_PHASES; p++) begin
            drain_results();
            set_config(SIZE_W'(phase_size[p]), COUNT_W'(phase_lim[p]));
            idle_on  = (p != N_PHASES - 1) && ($urandom_range(0, 3) != 0);
            pool_lim = sb.slot_count() * 3 / 2 + 2;
            if (pool_lim > POOL_KEYS)
                pool_lim = POOL_KEYS;
            repeat (PHASE_ITEMS) random_item(pool_lim);
        end

        drain_results();
        repeat (40) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
